>>> design/miu_pkg.sv
// Package for the MIPS32 integer execute unit: opcodes, function codes, states.
// No dependencies.
package miu_pkg;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_SPECIAL2 = 6'h1C;

  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_SRA  = 6'h03;
  localparam logic [5:0] FN_SLLV = 6'h04;
  localparam logic [5:0] FN_SRLV = 6'h06;
  localparam logic [5:0] FN_SRAV = 6'h07;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_JALR = 6'h09;
  localparam logic [5:0] FN_MOVZ = 6'h0A;
  localparam logic [5:0] FN_MOVN = 6'h0B;
  localparam logic [5:0] FN_MFHI = 6'h10;
  localparam logic [5:0] FN_MTHI = 6'h11;
  localparam logic [5:0] FN_MFLO = 6'h12;
  localparam logic [5:0] FN_MTLO = 6'h13;
  localparam logic [5:0] FN_MULT = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_DIV  = 6'h1A;
  localparam logic [5:0] FN_DIVU = 6'h1B;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_XOR  = 6'h26;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2A;
  localparam logic [5:0] FN_SLTU = 6'h2B;
  localparam logic [5:0] FN_TGE  = 6'h30;
  localparam logic [5:0] FN_TGEU = 6'h31;
  localparam logic [5:0] FN_TLT  = 6'h32;
  localparam logic [5:0] FN_TLTU = 6'h33;
  localparam logic [5:0] FN_TEQ  = 6'h34;
  localparam logic [5:0] FN_TNE  = 6'h36;

  localparam logic [5:0] FN2_MADD  = 6'h00;
  localparam logic [5:0] FN2_MADDU = 6'h01;
  localparam logic [5:0] FN2_MUL   = 6'h02;
  localparam logic [5:0] FN2_MSUB  = 6'h04;
  localparam logic [5:0] FN2_MSUBU = 6'h05;
  localparam logic [5:0] FN2_CLZ   = 6'h20;
  localparam logic [5:0] FN2_CLO   = 6'h21;

  localparam logic [4:0] RI_BLTZ   = 5'h00;
  localparam logic [4:0] RI_BGEZ   = 5'h01;
  localparam logic [4:0] RI_TGEI   = 5'h08;
  localparam logic [4:0] RI_TGEIU  = 5'h09;
  localparam logic [4:0] RI_TLTI   = 5'h0A;
  localparam logic [4:0] RI_TLTIU  = 5'h0B;
  localparam logic [4:0] RI_TEQI   = 5'h0C;
  localparam logic [4:0] RI_TNEI   = 5'h0E;
  localparam logic [4:0] RI_BLTZAL = 5'h10;
  localparam logic [4:0] RI_BGEZAL = 5'h11;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_TRAP = 2'd2;
  localparam logic [1:0] ST_NOEX = 2'd3;

  localparam logic [4:0] REG_SP = 5'd29;
  localparam logic [4:0] REG_RA = 5'd31;

  localparam logic CFG_RESET_PC = 1'b0;
  localparam logic CFG_INIT_SP  = 1'b1;

  // unit operation
  typedef enum logic [2:0] {
    U_NONE = 3'd0,
    U_MUL  = 3'd1,
    U_DIV  = 3'd2,
    U_CLZ  = 3'd3
  } uop_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RDA   = 7'b0000010,
    S_RDB   = 7'b0000100,
    S_EXEC  = 7'b0001000,
    S_ITER  = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

endpackage

>>> design/mips_integer_execute_unit.sv
// MIPS32 integer execute unit: register file memory, HI/LO, PC, sequencer with
// one shared shift-add / shift-subtract unit for multiply, divide and counting.
// Simple ops and divide by zero pass S_RDA, S_RDB, S_EXEC and S_ITER before out_valid;
// mult/div/madd/msub/mul/clo/clz also iterate the shared unit in S_ITER, then S_FIN.
// A new instruction is not taken until the previous result is transferred: input
// stalls until then. Register file is read through one port.
// Synchronous active-low reset: PC to RESET_PC_DEFAULT, HI/LO zero, registers cleared
// through valid bits, register 29 from INIT_SP_DEFAULT.
module mips_integer_execute_unit #(
  parameter int unsigned RESET_PC_DEFAULT = 32'h0040_0000,
  parameter int unsigned INIT_SP_DEFAULT  = 32'h00A0_0000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_instruction,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_write_enable,
  output logic [4:0]  out_write_index,
  output logic [31:0] out_write_value,
  output logic [31:0] out_next_pc,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import miu_pkg::*;

  logic [31:0] rf_mem [32];
  logic [31:0] rf_valid_r;
  logic [31:0] rf_q_r;
  logic [4:0]  rd_addr;

  state_t      state_r;
  logic [31:0] ins_r;
  logic [31:0] a_r, b_r;
  logic [31:0] pc_r, hi_r, lo_r, isp_r;
  logic [31:0] acc_hi_r, acc_lo_r, opnd_r;
  logic [5:0]  cnt_r;
  uop_t        uop_r;
  logic        neg_a_r, neg_b_r;

  logic [1:0]  o_status_r;
  logic        o_we_r;
  logic [4:0]  o_idx_r;
  logic [31:0] o_val_r, o_npc_r;
  logic        o_valid_r;

  logic        w_fire_out;
  logic [31:0] o_npc_nxt;
  logic        o_we_nxt;
  logic [4:0]  o_idx_nxt;
  logic [31:0] o_val_nxt;
  logic [1:0]  o_st_nxt;

  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sa;
  logic [31:0] imm, simm, pc4, btarget, jtarget;

  assign op = ins_r[31:26];
  assign fn = ins_r[5:0];
  assign rs = ins_r[25:21];
  assign rt = ins_r[20:16];
  assign rd = ins_r[15:11];
  assign sa = ins_r[10:6];
  assign imm = {16'd0, ins_r[15:0]};
  assign simm = {{16{ins_r[15]}}, ins_r[15:0]};
  assign pc4 = pc_r + 32'd4;
  assign btarget = pc4 + {simm[29:0], 2'b00};
  assign jtarget = {pc4[31:28], ins_r[25:0], 2'b00};

  assign in_stall = (state_r != S_IDLE) || o_valid_r || cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = o_valid_r;
  assign out_status = o_status_r;
  assign out_write_enable = o_we_r;
  assign out_write_index = o_idx_r;
  assign out_write_value = o_val_r;
  assign out_next_pc = o_npc_r;

  assign rd_addr = (state_r == S_RDA) ? rs : rt;

  // simple execution
  logic [1:0]  x_st;
  logic        x_wr, x_trap;
  logic [4:0]  x_dst;
  logic [31:0] x_val, x_npc, x_sum, x_dif, x_addi;
  logic        x_slt, x_sltu, x_slti, x_sltiu;
  uop_t        x_uop;
  logic        x_hi_we, x_lo_we;

  assign x_sum = a_r + b_r;
  assign x_dif = a_r - b_r;
  assign x_addi = a_r + simm;
  assign x_slt = $signed(a_r) < $signed(b_r);
  assign x_sltu = a_r < b_r;
  assign x_slti = $signed(a_r) < $signed(simm);
  assign x_sltiu = a_r < simm;

  always_comb begin
    x_st = ST_DONE; x_wr = 1'b0; x_trap = 1'b0; x_dst = rd; x_val = '0;
    x_npc = pc4; x_uop = U_NONE; x_hi_we = 1'b0; x_lo_we = 1'b0;
    case (op)
      OP_SPECIAL: begin
        case (fn)
          FN_SLL:  begin x_wr = 1'b1; x_val = b_r << sa; end
          FN_SRL:  begin x_wr = 1'b1; x_val = b_r >> sa; end
          FN_SRA:  begin x_wr = 1'b1; x_val = 32'($signed(b_r) >>> sa); end
          FN_SLLV: begin x_wr = 1'b1; x_val = b_r << a_r[4:0]; end
          FN_SRLV: begin x_wr = 1'b1; x_val = b_r >> a_r[4:0]; end
          FN_SRAV: begin x_wr = 1'b1; x_val = 32'($signed(b_r) >>> a_r[4:0]); end
          FN_JR:   x_npc = a_r;
          FN_JALR: begin x_npc = a_r; x_wr = 1'b1; x_val = pc4; end
          FN_MOVZ: begin x_wr = (b_r == '0); x_val = a_r; end
          FN_MOVN: begin x_wr = (b_r != '0); x_val = a_r; end
          FN_MFHI: begin x_wr = 1'b1; x_val = hi_r; end
          FN_MTHI: x_hi_we = 1'b1;
          FN_MFLO: begin x_wr = 1'b1; x_val = lo_r; end
          FN_MTLO: x_lo_we = 1'b1;
          FN_MULT, FN_MULTU: x_uop = U_MUL;
          FN_DIV, FN_DIVU: x_uop = U_DIV;
          FN_ADD: begin
            if (((a_r ^ x_sum) & (b_r ^ x_sum) & 32'h8000_0000) != '0) x_st = ST_OVF;
            else begin x_wr = 1'b1; x_val = x_sum; end
          end
          FN_ADDU: begin x_wr = 1'b1; x_val = x_sum; end
          FN_SUB: begin
            if (((a_r ^ b_r) & (a_r ^ x_dif) & 32'h8000_0000) != '0) x_st = ST_OVF;
            else begin x_wr = 1'b1; x_val = x_dif; end
          end
          FN_SUBU: begin x_wr = 1'b1; x_val = x_dif; end
          FN_AND: begin x_wr = 1'b1; x_val = a_r & b_r; end
          FN_OR:  begin x_wr = 1'b1; x_val = a_r | b_r; end
          FN_XOR: begin x_wr = 1'b1; x_val = a_r ^ b_r; end
          FN_NOR: begin x_wr = 1'b1; x_val = ~(a_r | b_r); end
          FN_SLT:  begin x_wr = 1'b1; x_val = {31'd0, x_slt}; end
          FN_SLTU: begin x_wr = 1'b1; x_val = {31'd0, x_sltu}; end
          FN_TGE:  x_trap = !x_slt;
          FN_TGEU: x_trap = !x_sltu;
          FN_TLT:  x_trap = x_slt;
          FN_TLTU: x_trap = x_sltu;
          FN_TEQ:  x_trap = (a_r == b_r);
          FN_TNE:  x_trap = (a_r != b_r);
          default: x_st = ST_NOEX;
        endcase
      end
      OP_REGIMM: begin
        case (rt)
          RI_BLTZ: if (a_r[31]) x_npc = btarget;
          RI_BGEZ: if (!a_r[31]) x_npc = btarget;
          RI_TGEI:  x_trap = !x_slti;
          RI_TGEIU: x_trap = !x_sltiu;
          RI_TLTI:  x_trap = x_slti;
          RI_TLTIU: x_trap = x_sltiu;
          RI_TEQI:  x_trap = (a_r == simm);
          RI_TNEI:  x_trap = (a_r != simm);
          RI_BLTZAL: begin
            if (a_r[31]) x_npc = btarget;
            x_wr = 1'b1; x_dst = REG_RA; x_val = pc4;
          end
          RI_BGEZAL: begin
            if (!a_r[31]) x_npc = btarget;
            x_wr = 1'b1; x_dst = REG_RA; x_val = pc4;
          end
          default: x_st = ST_NOEX;
        endcase
      end
      OP_J: x_npc = jtarget;
      OP_JAL: begin x_npc = jtarget; x_wr = 1'b1; x_dst = REG_RA; x_val = pc4; end
      OP_BEQ: if (a_r == b_r) x_npc = btarget;
      OP_BNE: if (a_r != b_r) x_npc = btarget;
      OP_BLEZ: if (a_r[31] || a_r == '0) x_npc = btarget;
      OP_BGTZ: if (!a_r[31] && a_r != '0) x_npc = btarget;
      OP_ADDI: begin
        x_dst = rt;
        if (((a_r ^ x_addi) & (simm ^ x_addi) & 32'h8000_0000) != '0) x_st = ST_OVF;
        else begin x_wr = 1'b1; x_val = x_addi; end
      end
      OP_ADDIU: begin x_dst = rt; x_wr = 1'b1; x_val = x_addi; end
      OP_SLTI:  begin x_dst = rt; x_wr = 1'b1; x_val = {31'd0, x_slti}; end
      OP_SLTIU: begin x_dst = rt; x_wr = 1'b1; x_val = {31'd0, x_sltiu}; end
      OP_ANDI:  begin x_dst = rt; x_wr = 1'b1; x_val = a_r & imm; end
      OP_ORI:   begin x_dst = rt; x_wr = 1'b1; x_val = a_r | imm; end
      OP_XORI:  begin x_dst = rt; x_wr = 1'b1; x_val = a_r ^ imm; end
      OP_LUI:   begin x_dst = rt; x_wr = 1'b1; x_val = {ins_r[15:0], 16'd0}; end
      OP_SPECIAL2: begin
        case (fn)
          FN2_MADD, FN2_MADDU, FN2_MSUB, FN2_MSUBU, FN2_MUL: x_uop = U_MUL;
          FN2_CLZ, FN2_CLO: x_uop = U_CLZ;
          default: x_st = ST_NOEX;
        endcase
      end
      default: x_st = ST_NOEX;
    endcase
    if (x_trap) x_st = ST_TRAP;
    if (x_st != ST_DONE) begin
      x_wr = 1'b0; x_npc = pc4; x_uop = U_NONE; x_hi_we = 1'b0; x_lo_we = 1'b0;
    end
  end

  // unit kind flags
  logic f_signed, f_acc, f_sub, f_mul3, f_clo;
  assign f_signed = (op == OP_SPECIAL) ? ((fn == FN_MULT) || (fn == FN_DIV))
                                       : (fn[0] == 1'b0);
  assign f_acc  = (op == OP_SPECIAL2) && (fn != FN2_MUL);
  assign f_sub  = fn[2];
  assign f_mul3 = (op == OP_SPECIAL2) && (fn == FN2_MUL);
  assign f_clo  = fn[0];

  // shared unit: one add/subtract per iteration
  logic [32:0] u_sum;
  logic        u_bit;
  always_comb begin
    u_bit = 1'b0;
    case (uop_r)
      U_MUL: u_sum = {1'b0, acc_hi_r} + (acc_lo_r[0] ? {1'b0, opnd_r} : 33'd0);
      U_DIV: u_sum = {acc_hi_r, acc_lo_r[31]} - {1'b0, opnd_r};
      U_CLZ: begin
        u_bit = (acc_lo_r[31] == f_clo) && (acc_hi_r[5:0] == (cnt_r - 6'd1));
        u_sum = {27'd0, acc_hi_r[5:0]} + {32'd0, u_bit};
      end
      default: u_sum = '0;
    endcase
  end

  // finishing: sign fix-up and accumulate
  logic [63:0] f_prod, f_accum;
  logic [31:0] f_q, f_r;
  assign f_prod = (neg_a_r ^ neg_b_r) ? (64'd0 - {acc_hi_r, acc_lo_r})
                                      : {acc_hi_r, acc_lo_r};
  assign f_accum = f_sub ? ({hi_r, lo_r} - f_prod) : ({hi_r, lo_r} + f_prod);
  assign f_q = (neg_a_r ^ neg_b_r) ? (32'd0 - acc_lo_r) : acc_lo_r;
  assign f_r = neg_a_r ? (32'd0 - acc_hi_r) : acc_hi_r;

  logic [31:0] abs_a, abs_b;
  logic        sa_neg, sb_neg;
  assign sa_neg = f_signed && a_r[31];
  assign sb_neg = f_signed && b_r[31];
  assign abs_a = sa_neg ? (32'd0 - a_r) : a_r;
  assign abs_b = sb_neg ? (32'd0 - b_r) : b_r;

  // output capture: simple ops and divide by zero decide at first S_ITER cycle, unit ops at S_FIN
  always_comb begin
    w_fire_out = 1'b0;
    o_npc_nxt = x_npc;
    o_we_nxt = 1'b0;
    if (state_r == S_ITER && cnt_r == 6'd0 && uop_r == U_NONE && x_uop == U_NONE) begin
      w_fire_out = 1'b1; o_npc_nxt = x_npc; o_we_nxt = x_wr && (x_dst != '0);
    end else if (state_r == S_ITER && cnt_r == 6'd0 && uop_r == U_NONE
                 && x_uop == U_DIV && b_r == '0) begin
      w_fire_out = 1'b1; o_npc_nxt = pc4;
    end else if (state_r == S_FIN) begin
      w_fire_out = 1'b1; o_npc_nxt = pc4;
      o_we_nxt = ((uop_r == U_CLZ) || f_mul3) && (rd != '0);
    end
  end

  always_comb begin
    o_st_nxt = ST_DONE;
    o_idx_nxt = rd;
    o_val_nxt = (uop_r == U_CLZ) ? acc_hi_r : f_prod[31:0];
    if (state_r == S_ITER) begin
      o_st_nxt = x_st; o_idx_nxt = x_dst; o_val_nxt = x_val;
    end
    if (!o_we_nxt) begin o_idx_nxt = '0; o_val_nxt = '0; end
  end

  // register file: one write port, one registered read port
  logic        gp_we;
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;
  assign gp_we = w_fire_out && o_we_nxt;

  always_comb begin
    rf_we = gp_we; rf_wa = o_idx_nxt; rf_wd = o_val_nxt;
    if (state_r == S_IDLE && cfg_valid && cfg_index == CFG_INIT_SP) begin
      rf_we = 1'b1; rf_wa = REG_SP; rf_wd = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we) rf_mem[rf_wa] <= rf_wd;
    rf_q_r <= rf_mem[rd_addr];
  end

  logic [31:0] rf_rd;
  logic [4:0]  rd_q_addr_r;
  always_ff @(posedge clk) rd_q_addr_r <= rd_addr;
  assign rf_rd = (rd_q_addr_r == '0) ? 32'd0 :
                 rf_valid_r[rd_q_addr_r] ? rf_q_r :
                 (rd_q_addr_r == REG_SP) ? isp_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      o_valid_r <= 1'b0;
      rf_valid_r <= '0;
      pc_r <= RESET_PC_DEFAULT;
      isp_r <= INIT_SP_DEFAULT;
      hi_r <= '0;
      lo_r <= '0;
      cnt_r <= '0;
      uop_r <= U_NONE;
    end else begin
      if (rf_we) rf_valid_r[rf_wa] <= 1'b1;
      case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == CFG_RESET_PC) pc_r <= cfg_data;
            else isp_r <= cfg_data;
          end else if (in_valid && !in_stall) begin
            ins_r <= in_instruction;
            state_r <= S_RDA;
          end
        end
        S_RDA: state_r <= S_RDB;
        S_RDB: begin a_r <= rf_rd; state_r <= S_EXEC; end
        S_EXEC: begin
          b_r <= rf_rd;
          state_r <= S_ITER;
          cnt_r <= '0;
          uop_r <= U_NONE;
        end
        S_ITER: begin
          if (cnt_r == 6'd0 && uop_r == U_NONE) begin
            // operands now in a_r/b_r; decide
            neg_a_r <= (x_uop == U_CLZ) ? 1'b0 : sa_neg;
            neg_b_r <= (x_uop == U_MUL) ? sb_neg : ((x_uop == U_DIV) ? sb_neg : 1'b0);
            if (x_uop == U_NONE) begin
              if (x_hi_we) hi_r <= a_r;
              if (x_lo_we) lo_r <= a_r;
              state_r <= S_OUT;
            end else if (x_uop == U_DIV && b_r == '0) begin
              lo_r <= 32'hFFFF_FFFF; hi_r <= a_r; state_r <= S_OUT;
            end else begin
              uop_r <= x_uop;
              acc_hi_r <= '0;
              acc_lo_r <= (x_uop == U_CLZ) ? a_r : abs_a;
              opnd_r <= abs_b;
              cnt_r <= 6'd1;
            end
          end else begin
            case (uop_r)
              U_MUL: begin
                acc_hi_r <= u_sum[32:1];
                acc_lo_r <= {u_sum[0], acc_lo_r[31:1]};
              end
              U_DIV: begin
                if (!u_sum[32]) begin
                  acc_hi_r <= u_sum[31:0];
                  acc_lo_r <= {acc_lo_r[30:0], 1'b1};
                end else begin
                  acc_hi_r <= {acc_hi_r[30:0], acc_lo_r[31]};
                  acc_lo_r <= {acc_lo_r[30:0], 1'b0};
                end
              end
              U_CLZ: begin
                acc_hi_r <= u_sum[31:0];
                acc_lo_r <= {acc_lo_r[30:0], 1'b0};
              end
              default: ;
            endcase
            cnt_r <= cnt_r + 6'd1;
            if (cnt_r == 6'd32) state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (uop_r == U_MUL && !f_mul3) begin
            if (f_acc) begin hi_r <= f_accum[63:32]; lo_r <= f_accum[31:0]; end
            else begin hi_r <= f_prod[63:32]; lo_r <= f_prod[31:0]; end
          end
          if (uop_r == U_DIV) begin lo_r <= f_q; hi_r <= f_r; end
          state_r <= S_OUT;
        end
        S_OUT: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (w_fire_out) begin
        o_valid_r <= 1'b1;
        pc_r <= o_npc_nxt;
      end else if (o_valid_r && !out_stall) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (w_fire_out) begin
      o_status_r <= o_st_nxt;
      o_we_r <= o_we_nxt;
      o_idx_r <= o_idx_nxt;
      o_val_r <= o_val_nxt;
      o_npc_r <= o_npc_nxt;
    end
  end

endmodule

>>> dv/mips_integer_execute_unit_tb.sv
// Testbench for the MIPS32 integer execute unit: drives instruction words,
// predicts register writes, status and next PC in a scoreboard class.
// Depends on miu_pkg and mips_integer_execute_unit.
`timescale 1ns / 100ps

module mips_integer_execute_unit_tb;
  import miu_pkg::*;

  localparam logic [5:0] OP_LW = 6'h23;

  typedef struct packed {
    logic [1:0]  status;
    logic        we;
    logic [4:0]  idx;
    logic [31:0] value;
    logic [31:0] npc;
  } exec_result_t;

  class exec_scoreboard;
    logic [31:0] gpr [32];
    logic [31:0] hi, lo, pc;
    exec_result_t pending [$];
    int errors;

    function void reset_state(logic [31:0] rpc, logic [31:0] sp);
      foreach (gpr[i]) gpr[i] = '0;
      gpr[REG_SP] = sp;
      hi = '0;
      lo = '0;
      pc = rpc;
    endfunction

    function void set_pc(logic [31:0] v);
      pc = v;
    endfunction

    function void set_sp(logic [31:0] v);
      gpr[REG_SP] = v;
    endfunction

    function logic [63:0] mul64(logic [31:0] a, logic [31:0] b, bit sgn);
      if (sgn) return $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
      return {32'b0, a} * {32'b0, b};
    endfunction

    function logic [31:0] lead_count(logic [31:0] v, bit b);
      int n;
      n = 0;
      while (n < 32 && v[31 - n] == b) n++;
      return 32'(n);
    endfunction

    function void divide(logic [31:0] a, logic [31:0] b, bit sgn);
      logic [31:0] ua, ub, q, r;
      bit na, nb;
      na = 0;
      nb = 0;
      ua = a;
      ub = b;
      if (b == 0) begin
        lo = '1;
        hi = a;
        return;
      end
      if (sgn) begin
        na = a[31];
        nb = b[31];
        if (na) ua = -a;
        if (nb) ub = -b;
      end
      q = ua / ub;
      r = ua % ub;
      if (na != nb) q = -q;
      if (na) r = -r;
      lo = q;
      hi = r;
    endfunction

    function void note_instruction(logic [31:0] ins);
      logic [5:0] op, fn;
      logic [4:0] rs, rt, rd, sa, dst;
      logic [31:0] a, b, imm, simm, pc4, bt, npc, val, r;
      logic [63:0] acc;
      logic [1:0] st;
      bit wr, trap, sgn;
      exec_result_t e;
      op = ins[31:26];
      fn = ins[5:0];
      rs = ins[25:21];
      rt = ins[20:16];
      rd = ins[15:11];
      sa = ins[10:6];
      a = gpr[rs];
      b = gpr[rt];
      imm = {16'b0, ins[15:0]};
      simm = {{16{ins[15]}}, ins[15:0]};
      pc4 = pc + 32'd4;
      bt = pc4 + (simm << 2);
      npc = pc4;
      st = ST_DONE;
      dst = '0;
      val = '0;
      wr = 0;
      trap = 0;
      case (op)
        OP_SPECIAL: begin
          case (fn)
            FN_SLL: begin wr = 1; dst = rd; val = b << sa; end
            FN_SRL: begin wr = 1; dst = rd; val = b >> sa; end
            FN_SRA: begin wr = 1; dst = rd; val = $signed(b) >>> sa; end
            FN_SLLV: begin wr = 1; dst = rd; val = b << a[4:0]; end
            FN_SRLV: begin wr = 1; dst = rd; val = b >> a[4:0]; end
            FN_SRAV: begin wr = 1; dst = rd; val = $signed(b) >>> a[4:0]; end
            FN_JR: npc = a;
            FN_JALR: begin npc = a; wr = 1; dst = rd; val = pc4; end
            FN_MOVZ: if (b == 0) begin wr = 1; dst = rd; val = a; end
            FN_MOVN: if (b != 0) begin wr = 1; dst = rd; val = a; end
            FN_MFHI: begin wr = 1; dst = rd; val = hi; end
            FN_MTHI: hi = a;
            FN_MFLO: begin wr = 1; dst = rd; val = lo; end
            FN_MTLO: lo = a;
            FN_MULT, FN_MULTU: begin
              acc = mul64(a, b, fn == FN_MULT);
              {hi, lo} = acc;
            end
            FN_DIV: divide(a, b, 1);
            FN_DIVU: divide(a, b, 0);
            FN_ADD: begin
              r = a + b;
              if ((a[31] ^ r[31]) & (b[31] ^ r[31])) st = ST_OVF;
              else begin wr = 1; dst = rd; val = r; end
            end
            FN_ADDU: begin wr = 1; dst = rd; val = a + b; end
            FN_SUB: begin
              r = a - b;
              if ((a[31] ^ b[31]) & (a[31] ^ r[31])) st = ST_OVF;
              else begin wr = 1; dst = rd; val = r; end
            end
            FN_SUBU: begin wr = 1; dst = rd; val = a - b; end
            FN_AND: begin wr = 1; dst = rd; val = a & b; end
            FN_OR: begin wr = 1; dst = rd; val = a | b; end
            FN_XOR: begin wr = 1; dst = rd; val = a ^ b; end
            FN_NOR: begin wr = 1; dst = rd; val = ~(a | b); end
            FN_SLT: begin wr = 1; dst = rd; val = {31'b0, $signed(a) < $signed(b)}; end
            FN_SLTU: begin wr = 1; dst = rd; val = {31'b0, a < b}; end
            FN_TGE: trap = !($signed(a) < $signed(b));
            FN_TGEU: trap = a >= b;
            FN_TLT: trap = $signed(a) < $signed(b);
            FN_TLTU: trap = a < b;
            FN_TEQ: trap = a == b;
            FN_TNE: trap = a != b;
            default: st = ST_NOEX;
          endcase
        end
        OP_REGIMM: begin
          case (rt)
            RI_BLTZ: if (a[31]) npc = bt;
            RI_BGEZ: if (!a[31]) npc = bt;
            RI_TGEI: trap = !($signed(a) < $signed(simm));
            RI_TGEIU: trap = a >= simm;
            RI_TLTI: trap = $signed(a) < $signed(simm);
            RI_TLTIU: trap = a < simm;
            RI_TEQI: trap = a == simm;
            RI_TNEI: trap = a != simm;
            RI_BLTZAL: begin
              if (a[31]) npc = bt;
              wr = 1; dst = REG_RA; val = pc4;
            end
            RI_BGEZAL: begin
              if (!a[31]) npc = bt;
              wr = 1; dst = REG_RA; val = pc4;
            end
            default: st = ST_NOEX;
          endcase
        end
        OP_J, OP_JAL: begin
          npc = {pc4[31:28], ins[25:0], 2'b00};
          if (op == OP_JAL) begin wr = 1; dst = REG_RA; val = pc4; end
        end
        OP_BEQ: if (a == b) npc = bt;
        OP_BNE: if (a != b) npc = bt;
        OP_BLEZ: if (a[31] || a == 0) npc = bt;
        OP_BGTZ: if (!a[31] && a != 0) npc = bt;
        OP_ADDI: begin
          r = a + simm;
          if ((a[31] ^ r[31]) & (simm[31] ^ r[31])) st = ST_OVF;
          else begin wr = 1; dst = rt; val = r; end
        end
        OP_ADDIU: begin wr = 1; dst = rt; val = a + simm; end
        OP_SLTI: begin wr = 1; dst = rt; val = {31'b0, $signed(a) < $signed(simm)}; end
        OP_SLTIU: begin wr = 1; dst = rt; val = {31'b0, a < simm}; end
        OP_ANDI: begin wr = 1; dst = rt; val = a & imm; end
        OP_ORI: begin wr = 1; dst = rt; val = a | imm; end
        OP_XORI: begin wr = 1; dst = rt; val = a ^ imm; end
        OP_LUI: begin wr = 1; dst = rt; val = imm << 16; end
        OP_SPECIAL2: begin
          case (fn)
            FN2_MADD, FN2_MADDU, FN2_MSUB, FN2_MSUBU: begin
              sgn = (fn == FN2_MADD) || (fn == FN2_MSUB);
              acc = {hi, lo};
              if (fn == FN2_MSUB || fn == FN2_MSUBU) acc = acc - mul64(a, b, sgn);
              else acc = acc + mul64(a, b, sgn);
              {hi, lo} = acc;
            end
            FN2_MUL: begin
              acc = mul64(a, b, 1);
              wr = 1; dst = rd; val = acc[31:0];
            end
            FN2_CLZ: begin wr = 1; dst = rd; val = lead_count(a, 0); end
            FN2_CLO: begin wr = 1; dst = rd; val = lead_count(a, 1); end
            default: st = ST_NOEX;
          endcase
        end
        default: st = ST_NOEX;
      endcase
      if (trap) st = ST_TRAP;
      if (st != ST_DONE) begin wr = 0; npc = pc4; end
      if (!wr || dst == 0) begin wr = 0; dst = '0; val = '0; end
      else gpr[dst] = val;
      pc = npc;
      e.status = st;
      e.we = wr;
      e.idx = dst;
      e.value = val;
      e.npc = npc;
      pending.push_back(e);
    endfunction

    function void check_result(exec_result_t got);
      exec_result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status)
        $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
      if (got.we !== exp.we)
        $display("%0t: write_enable exp %0d got %0d", $time, exp.we, got.we);
      if (got.idx !== exp.idx)
        $display("%0t: write_index exp %0d got %0d", $time, exp.idx, got.idx);
      if (got.value !== exp.value)
        $display("%0t: write_value exp %h got %h", $time, exp.value, got.value);
      if (got.npc !== exp.npc)
        $display("%0t: next_pc exp %h got %h", $time, exp.npc, got.npc);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [31:0] in_instruction = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] out_status;
  logic out_write_enable;
  logic [4:0] out_write_index;
  logic [31:0] out_write_value;
  logic [31:0] out_next_pc;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic cfg_index = CFG_RESET_PC;
  logic [31:0] cfg_data = '0;

  mips_integer_execute_unit dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  exec_scoreboard sb = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_status, out_write_enable, out_write_index,
                       out_write_value, out_next_pc});
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    out_stall <= ($urandom_range(99) < stall_pct);
    if (quiet_cycles > 20000) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_instruction(logic [31:0] ins);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_instruction <= ins;
    do @(posedge clk); while (in_stall);
    sb.note_instruction(ins);
  endtask

  task automatic write_cfg(logic idx, logic [31:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_INIT_SP) sb.set_sp(v);
    else sb.set_pc(v);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [31:0] r_type(logic [5:0] fn);
    return {OP_SPECIAL, 5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom), fn};
  endfunction

  function automatic logic [31:0] random_instruction();
    logic [31:0] w;
    logic [5:0] fns [] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR,
      FN_JALR, FN_MOVZ, FN_MOVN, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT,
      FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR,
      FN_XOR, FN_NOR, FN_SLT, FN_SLTU, FN_TGE, FN_TGEU, FN_TLT, FN_TLTU, FN_TEQ,
      FN_TNE};
    logic [5:0] fn2s [] = '{FN2_MADD, FN2_MADDU, FN2_MUL, FN2_MSUB, FN2_MSUBU,
      FN2_CLZ, FN2_CLO};
    logic [4:0] ris [] = '{RI_BLTZ, RI_BGEZ, RI_TGEI, RI_TGEIU, RI_TLTI, RI_TLTIU,
      RI_TEQI, RI_TNEI, RI_BLTZAL, RI_BGEZAL};
    w = $urandom;
    case ($urandom_range(9))
      0, 1, 2: w = r_type(fns[$urandom_range(fns.size() - 1)]);
      3: w[31:26] = OP_SPECIAL2;
      4: begin w[31:26] = OP_SPECIAL2; w[5:0] = fn2s[$urandom_range(6)]; end
      5: begin w[31:26] = OP_REGIMM; w[20:16] = ris[$urandom_range(9)]; end
      6, 7: w[31:26] = 6'($urandom_range(OP_J, OP_LUI));
      8: w[31:26] = OP_LUI;
      default: ;
    endcase
    // keep source values interesting: immediates often at extremes
    if ($urandom_range(7) == 0) w[15:0] = $urandom_range(1) ? 16'hFFFF : 16'h8000;
    return w;
  endfunction

  initial begin
    logic [31:0] dir [$];
    int phase_idle [4] = '{0, 80, 0, 25};
    int phase_stall [4] = '{0, 0, 80, 25};
    repeat (11) @(posedge clk);
    rst_n <= 1;
    sb.reset_state(32'h0040_0000, 32'h00A0_0000);
    @(posedge clk);
    // directed: extremes, overflow, traps, division corners, zero register
    dir = '{{OP_LUI, 5'd0, 5'd1, 16'h8000}, {OP_ADDIU, 5'd0, 5'd2, 16'hFFFF},
      {OP_SPECIAL, 5'd1, 5'd1, 5'd3, 5'd0, FN_ADD},
      {OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd0, FN_SUB},
      {OP_ADDI, 5'd1, 5'd4, 16'hFFFF}, {OP_LUI, 5'd0, 5'd0, 16'h1234},
      {OP_SPECIAL, 5'd1, 5'd2, 5'd0, 5'd0, FN_DIV},
      {OP_SPECIAL, 5'd0, 5'd0, 5'd10, 5'd0, FN_MFLO},
      {OP_SPECIAL, 5'd1, 5'd0, 5'd0, 5'd0, FN_DIVU},
      {OP_SPECIAL, 5'd0, 5'd0, 5'd11, 5'd0, FN_MFHI},
      {OP_SPECIAL2, 5'd1, 5'd0, 5'd12, 5'd0, FN2_CLZ},
      {OP_SPECIAL2, 5'd2, 5'd0, 5'd13, 5'd0, FN2_CLO},
      {OP_SPECIAL2, 5'd0, 5'd0, 5'd13, 5'd0, FN2_CLZ},
      {OP_SPECIAL, 5'd2, 5'd2, 5'd0, 5'd0, FN_TEQ},
      {OP_REGIMM, 5'd2, RI_BGEZAL, 16'h0004}, {OP_REGIMM, 5'd2, RI_BLTZAL, 16'hFFFC},
      {OP_SPECIAL, 5'd31, 5'd0, 5'd31, 5'd0, FN_JALR},
      {OP_JAL, 26'h3FF_FFFF}, {OP_J, 26'h0}, {OP_LW, 26'h123},
      {OP_SPECIAL2, 5'd1, 5'd2, 5'd0, 5'd0, FN2_MSUB},
      {OP_SPECIAL, 5'd29, 5'd1, 5'd5, 5'd31, FN_SRA}, 32'hFFFF_FFFF};
    foreach (dir[i]) send_instruction(dir[i]);
    drain();
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      case (p)
        0: write_cfg(CFG_RESET_PC, 32'hFFFF_FFF0);
        1: write_cfg(CFG_INIT_SP, 32'hFFFF_FFFF);
        2: begin write_cfg(CFG_RESET_PC, 32'h0); write_cfg(CFG_INIT_SP, 32'h0); end
        default: write_cfg(CFG_RESET_PC, $urandom);
      endcase
      cfg_valid <= 0;
      repeat (350) send_instruction(random_instruction());
      drain();
    end
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
